### src/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the priority-removal queue: request and
// result words, request and status codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
package fpr_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int PAYLOAD_BITS  = 32;
   localparam int PRIORITY_BITS = 8;
   localparam int OCC_BITS      = 5;
   localparam int REQ_BITS      = 2;
   localparam int STATUS_BITS   = 2;

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_PUSH   = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_POP    = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [REQ_BITS-1:0]      req_type;
      logic [PAYLOAD_BITS-1:0]  payload;
      logic [PRIORITY_BITS-1:0] priority_req;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [PAYLOAD_BITS-1:0]  out_payload;
      logic [PRIORITY_BITS-1:0] out_priority;
      logic [OCC_BITS-1:0]      occupancy;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic                   load;        // latch request, clear result
      logic                   push;        // write tail entry, count up
      logic                   set_status;  // record error status
      logic [STATUS_BITS-1:0] status;
      logic                   scan;        // read next entry for compare
      logic                   take;        // copy best entry to result
      logic                   drop_head;   // advance head, count down
      logic                   shift;       // move one entry toward head
      logic                   dec;         // count down after compaction
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [REQ_BITS-1:0] kind;
      logic                empty;
      logic                full;
      logic                scan_last;
      logic                best_at_head;
      logic                shift_more;
   } dp_stat_type;

endpackage

### src/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fpr_dp.sv
// ----------------------------------------------------------------------------
// fpr_dp
// Datapath: circular entry store with head pointer and fill count, scan
// compare for the highest priority, and one-entry-a-cycle compaction.
// ----------------------------------------------------------------------------
module fpr_dp #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fpr_pkg::req_word_type req_word,
   input  fpr_pkg::dp_cmd_type  cmd,
   output fpr_pkg::dp_stat_type stat,
   output fpr_pkg::rsp_word_type rsp_word
);
   import fpr_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int ENT_W = PAYLOAD_BITS + PRIORITY_BITS;

   // slot of the entry at offset off from the head, wrapped once
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   req_word_type          req_ff, req_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic                  cmp_v_ff, cmp_v_in;
   logic [CNT_W-1:0]      cmp_k_ff, cmp_k_in;
   logic                  mv_v_ff, mv_v_in;
   logic [CNT_W-1:0]      mv_k_ff, mv_k_in;
   logic [CNT_W-1:0]      best_k_ff, best_k_in;
   logic [ENT_W-1:0]      best_ent_ff, best_ent_in;
   logic [ENT_W-1:0]      res_ent_ff, res_ent_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENT_W-1:0]      wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENT_W-1:0]      rd_data;
   logic [CNT_W-1:0]      k_next;
   logic [CNT_W-1:0]      scan_limit;

   assign k_next     = k_ff + CNT_W'(1);
   assign scan_limit = (req_ff.req_type == REQ_POP) ? CNT_W'(1) : count_ff;

   // entry store
   fpr_ram #(
      .WIDTH(ENT_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // read the scanned entry, or the one behind the gap when compacting
   assign rd_addr = cmd.shift ? slot(head_ff, k_next) : slot(head_ff, k_ff);

   // write the moved entry in the cycle after its read, else a pushed entry
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot(head_ff, count_ff);
      wr_data = {req_ff.payload, req_ff.priority_req};
      if (mv_v_ff) begin
         wr_en   = 1'b1;
         wr_addr = slot(head_ff, mv_k_ff);
         wr_data = rd_data;
      end else if (cmd.push) begin
         wr_en   = 1'b1;
      end
   end

   // next-state logic for the datapath registers
   always_comb begin
      req_in      = req_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      best_k_in   = best_k_ff;
      best_ent_in = best_ent_ff;
      res_ent_in  = res_ent_ff;
      status_in   = status_ff;
      cmp_v_in    = cmd.scan;
      cmp_k_in    = k_ff;
      mv_v_in     = cmd.shift;
      mv_k_in     = k_ff;

      if (cmd.load) begin
         req_in     = req_word;
         k_in       = '0;
         status_in  = ST_OK;
         res_ent_in = '0;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.scan || cmd.shift) begin
         k_in = k_next;
      end
      // keep the first entry of the highest priority
      if (cmp_v_ff && ((cmp_k_ff == '0) ||
          (rd_data[PRIORITY_BITS-1:0] > best_ent_ff[PRIORITY_BITS-1:0]))) begin
         best_ent_in = rd_data;
         best_k_in   = cmp_k_ff;
      end
      if (cmd.take) begin
         res_ent_in = best_ent_ff;
         k_in       = best_k_ff;
      end
      if (cmd.drop_head) begin
         head_in  = slot(head_ff, CNT_W'(1));
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         k_ff     <= '0;
         cmp_v_ff <= 1'b0;
         mv_v_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         cmp_v_ff <= cmp_v_in;
         mv_v_ff  <= mv_v_in;
      end
      req_ff      <= req_in;
      cmp_k_ff    <= cmp_k_in;
      mv_k_ff     <= mv_k_in;
      best_k_ff   <= best_k_in;
      best_ent_ff <= best_ent_in;
      res_ent_ff  <= res_ent_in;
      status_ff   <= status_in;
   end

   // status to the controller
   assign stat.kind         = req_ff.req_type;
   assign stat.empty        = (count_ff == '0);
   assign stat.full         = (count_ff == CNT_W'(DEPTH));
   assign stat.scan_last    = (k_next >= scan_limit);
   assign stat.best_at_head = (best_k_ff == '0);
   assign stat.shift_more   = (k_next < count_ff);

   // result word
   assign rsp_word.status       = status_ff;
   assign rsp_word.out_payload  = res_ent_ff[ENT_W-1:PRIORITY_BITS];
   assign rsp_word.out_priority = res_ent_ff[PRIORITY_BITS-1:0];
   assign rsp_word.occupancy    = OCC_BITS'(count_ff);

endmodule

### src/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Controller: sequences dispatch, priority scan, pick, compaction and the
// one-cycle result strobe.
// ----------------------------------------------------------------------------
module fpr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fpr_pkg::dp_stat_type stat,
   output fpr_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);
   import fpr_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      DISPATCH,
      SCAN,
      SCAN_DRAIN,
      PICK,
      SHIFT,
      RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_OK;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            state_in = RESP;
            unique case (stat.kind)
               REQ_PUSH: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               REQ_POP, REQ_REMOVE: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     state_in = SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = SCAN_DRAIN;
            end
         end
         SCAN_DRAIN: begin
            state_in = PICK;
         end
         PICK: begin
            cmd.take = 1'b1;
            if (stat.best_at_head) begin
               cmd.drop_head = 1'b1;
               state_in      = RESP;
            end else begin
               state_in = SHIFT;
            end
         end
         SHIFT: begin
            if (stat.shift_more) begin
               cmd.shift = 1'b1;
            end else begin
               cmd.dec  = 1'b1;
               state_in = RESP;
            end
         end
         RESP: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != IDLE);
         strobe_ff <= (state_in == RESP);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

### src/fifo_with_priority_removal.sv
// ----------------------------------------------------------------------------
// fifo_with_priority_removal
// Ordered queue of up to DEPTH entries with push, pop and removal of the
// highest-priority entry; every request returns one result word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_word and raise start; the word is taken at a
//   rising edge where start is high and busy is low. busy rises the cycle
//   after and stays high until the result has gone out.
//   Result channel: rsp_word is valid for exactly one cycle, marked by
//   rsp_strobe. The receiver cannot stall; it must take the word that cycle.
//   A request is not taken while busy is high, so each one finishes before
//   the next is accepted. A push, or any request that ends in an error or
//   is unused, goes straight to its result. A pop reads only the head entry;
//   a removal scans all n held entries and, unless the best is at the head,
//   then closes the gap by moving the entries behind it toward the head.
//   The rate is set by the single-port read of the entry store: the priority
//   scan reads one entry a cycle, and compaction moves one entry a cycle
//   toward the head. busy drops in the cycle after the result strobe.
//   Reset (synchronous, active high) empties the queue at once; no clearing
//   pass runs, as only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module fifo_with_priority_removal #(
   parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fpr_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output fpr_pkg::rsp_word_type rsp_word
);
   import fpr_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   // store, scan and compaction
   fpr_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_word(req_word),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_word(rsp_word)
   );

endmodule

### src/fpr_chk.sv
// ----------------------------------------------------------------------------
// fpr_chk
// Port-level checker for the priority-removal queue, bound to the top level.
// ----------------------------------------------------------------------------
module fpr_chk #(
   parameter int DEPTH = fpr_pkg::DEPTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input fpr_pkg::rsp_word_type rsp_word
);
   import fpr_pkg::*;

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a result goes out only while busy, and the block is free right after
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 !busy)
      else $error("result strobe outside of a busy request");

   // a full status reports a full queue
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status == ST_FULL)) |->
      (rsp_word.occupancy == OCC_BITS'(DEPTH)))
      else $error("full status with queue not full");

   // an empty status reports an empty queue and no removed word
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status == ST_EMPTY)) |->
      ((rsp_word.occupancy == '0) && (rsp_word.out_payload == '0) &&
       (rsp_word.out_priority == '0)))
      else $error("empty status with entries or data");

endmodule

bind fifo_with_priority_removal fpr_chk #(
   .DEPTH(DEPTH)
) u_fpr_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_word  (rsp_word)
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the priority-removal queue against a predictor kept in step with
// every accepted request word. Directed words cover the empty and full cases,
// the unused request code, field extremes and priority ties. Random words then
// sweep the queue between empty and full with sender gaps of varying density.
// Each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import fpr_pkg::*;

   localparam int QUEUE_DEPTH    = DEPTH_DEF;
   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int PRINT_LIMIT    = 100;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic         rsp_strobe;
   req_word_type req_word;
   rsp_word_type rsp_word;

   // predictor state: held entries, head at slot 0
   logic [PAYLOAD_BITS-1:0]  held_payloads   [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] held_priorities [QUEUE_DEPTH];
   int held_count;

   rsp_word_type expected_words[$];
   int mismatch_count;
   int words_sent;
   int words_checked;
   int full_hits;
   int empty_hits;
   int removals;
   int idle_percent;
   int quiet_cycles;

   fifo_with_priority_removal dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one request to the predicted queue and return its result word.
   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int best;
      r = '0;
      r.status = ST_OK;
      case (w.req_type)
         REQ_PUSH: begin
            if (held_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               held_payloads[held_count]   = w.payload;
               held_priorities[held_count] = w.priority_req;
               held_count++;
            end
         end
         REQ_POP, REQ_REMOVE: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               best = 0;
               // strict compare keeps the tie nearest the head
               if (w.req_type == REQ_REMOVE) begin
                  for (int i = 1; i < held_count; i++)
                     if (held_priorities[i] > held_priorities[best])
                        best = i;
               end
               r.out_payload  = held_payloads[best];
               r.out_priority = held_priorities[best];
               // close the gap, keep order of the rest
               for (int i = best; i + 1 < held_count; i++) begin
                  held_payloads[i]   = held_payloads[i + 1];
                  held_priorities[i] = held_priorities[i + 1];
               end
               held_count--;
            end
         end
         default: ;
      endcase
      r.occupancy = held_count[OCC_BITS-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h (result %0d)",
                  $time, what, want, got, words_checked);
      mismatch_count++;
   endtask

   // Offer one request word and hold it until the queue takes it.
   task automatic send_word(input req_word_type w);
      rsp_word_type r;
      @(negedge clock);
      req_word <= w;
      start    <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      r = apply_request(w);
      expected_words.push_back(r);
      words_sent++;
      if (r.status == ST_FULL) full_hits++;
      if (r.status == ST_EMPTY) empty_hits++;
      if (w.req_type == REQ_REMOVE && r.status == ST_OK) removals++;
   endtask

   // Drop start for a random gap, mostly short, now and then long.
   task automatic sender_gap();
      int gap;
      if ($urandom_range(99) < idle_percent) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic req_word_type make_word(input logic [REQ_BITS-1:0] kind,
                                              input logic [PAYLOAD_BITS-1:0] pay,
                                              input logic [PRIORITY_BITS-1:0] pri);
      req_word_type w;
      w.req_type     = kind;
      w.payload      = pay;
      w.priority_req = pri;
      return w;
   endfunction

   // Pop, remove and an unused code on a fresh, empty queue.
   task automatic test_empty_queue();
      idle_percent = 0;
      send_word(make_word(REQ_POP, '1, '1));
      send_word(make_word(REQ_REMOVE, '0, '0));
      send_word(make_word(REQ_UNUSED, '1, '1));
   endtask

   // Fill to capacity with extreme fields and two top-priority ties, then overflow.
   task automatic test_fill_to_full();
      logic [PAYLOAD_BITS-1:0]  pay;
      logic [PRIORITY_BITS-1:0] pri;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (i == 0) pay = '0;
         else if (i == QUEUE_DEPTH - 1) pay = '1;
         else pay = {8{4'(i)}};
         pri = (i == 5 || i == 12) ? 8'hFF : 8'(i * 5);
         send_word(make_word(REQ_PUSH, pay, pri));
      end
      send_word(make_word(REQ_PUSH, '1, '1));
   endtask

   // Removal picks the tie nearest the head; pop still takes the head.
   task automatic test_removal_order();
      send_word(make_word(REQ_REMOVE, '0, '0));
      send_word(make_word(REQ_REMOVE, '1, '1));
      send_word(make_word(REQ_POP, '0, '0));
      send_word(make_word(REQ_UNUSED, '1, '1));
      send_word(make_word(REQ_REMOVE, '0, '0));
   endtask

   // Random words in stretches that lean toward filling, draining or neither.
   task automatic test_random_traffic(input int count, input int idle_pct);
      req_word_type w;
      int sent;
      int step;
      int push_pct;
      int pri_span;
      int roll;
      idle_percent = idle_pct;
      sent = 0;
      step = 0;
      push_pct = 50;
      pri_span = 255;
      while (sent < count) begin
         if (step % 24 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
            pri_span = $urandom_range(1) ? 255 : 3;
         end
         step++;
         w.payload      = $urandom();
         w.priority_req = 8'($urandom_range(pri_span));
         roll = $urandom_range(99);
         if (roll < 3) w.req_type = REQ_UNUSED;
         else if ($urandom_range(99) < push_pct) w.req_type = REQ_PUSH;
         else if ($urandom_range(2) == 0) w.req_type = REQ_POP;
         else w.req_type = REQ_REMOVE;
         send_word(w);
         sender_gap();
         if (w.req_type != REQ_UNUSED) sent++;
      end
   endtask

   // Compare each result word with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing expected", '0, 32'(rsp_word));
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_word.status));
            if (rsp_word.out_payload !== want.out_payload)
               report_mismatch("out_payload", want.out_payload, rsp_word.out_payload);
            if (rsp_word.out_priority !== want.out_priority)
               report_mismatch("out_priority", 32'(want.out_priority),
                               32'(rsp_word.out_priority));
            if (rsp_word.occupancy !== want.occupancy)
               report_mismatch("occupancy", 32'(want.occupancy), 32'(rsp_word.occupancy));
            words_checked++;
         end
      end
   end

   // End the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no word moved for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_word       = '0;
      held_count     = 0;
      mismatch_count = 0;
      words_sent     = 0;
      words_checked  = 0;
      full_hits      = 0;
      empty_hits     = 0;
      removals       = 0;
      idle_percent   = 0;
      quiet_cycles   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_fill_to_full();
      test_removal_order();
      test_random_traffic(360, 0);
      test_random_traffic(360, 58);
      test_random_traffic(360, 35);

      // drain: wait for every result, then a quiet stretch for stray words
      @(negedge clock);
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request words, %0d results checked", words_sent,
               words_checked);
      $display("full pushes %0d, empty removals %0d, priority removals %0d",
               full_hits, empty_hits, removals);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
src/fpr_pkg.sv
src/fpr_ram.sv
src/fpr_dp.sv
src/fpr_ctrl.sv
src/fifo_with_priority_removal.sv
src/fpr_chk.sv
test/tb.sv
